FILE: hdl/rsrd_pkg.sv
// Package for the RGBE scanline run-length decoder.
// Holds the shared sizes and the RGBE-to-binary32 conversion; depends on nothing.
package rsrd_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int RW_W       = 13;
    localparam int BYTE_W     = 8;
    localparam int FLT_W      = 32;
    localparam logic [BYTE_W-1:0] MAGIC_BYTE = 8'h02;
    localparam logic [BYTE_W-1:0] RUN_BASE   = 8'd128;
    localparam logic [9:0]        EXP_OFFSET = 10'd9;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_MAGIC    = 3'd1;
    localparam logic [2:0] ERR_WIDTH    = 3'd2;
    localparam logic [2:0] ERR_ZERO_RUN = 3'd3;
    localparam logic [2:0] ERR_OVERRUN  = 3'd4;

    // Exact binary32 value of m * 2^(e - 136).
    function automatic logic [FLT_W-1:0] rgbe_to_float(input logic [7:0] m,
                                                       input logic [7:0] e);
        logic [2:0]  p;
        logic [9:0]  biased;
        logic [31:0] frac;
        logic [4:0]  sh;
        p = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (m[i]) p = 3'(i);
        end
        biased = {2'b00, e} + {7'b0, p} - EXP_OFFSET;
        frac   = {24'b0, m} << (5'd23 - {2'b00, p});
        sh     = e[4:0] + 5'd13;
        if (m == 8'd0) begin
            rgbe_to_float = '0;
        end else if (!biased[9] && biased != 10'd0) begin
            rgbe_to_float = {1'b0, biased[7:0], frac[22:0]};
        end else begin
            rgbe_to_float = {24'b0, m} << sh;
        end
    endfunction

endpackage

FILE: hdl/rsrd_ram.sv
// Generic single-port RAM with registered read data.
// Used for the red, green and blue line stores; no dependencies.
module rsrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: hdl/rgbe_scanline_rle_decoder.sv
// Top level of the RGBE scanline run-length decoder.
// Depends on rsrd_pkg and rsrd_ram.
//
// Bytes of a coded scanline enter one per request. A header or count byte is
// only accepted. An R, G or B literal byte is accepted, then written to the
// line store. An R, G or B run of n bytes is accepted, then written once per
// pixel to the line store. An exponent byte is accepted, then each pixel it
// decodes takes a line-store read and three passes through the single shared
// float converter. Each result then passes through the emit state, plus any
// back-pressure wait, when it is handed to the output register; an error result
// does the same. The block holds s_ready low while a byte is being worked.
module rgbe_scanline_rle_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [rsrd_pkg::RW_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rsrd_pkg::BYTE_W-1:0]   s_data_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rsrd_pkg::ADDR_W-1:0]   m_pixel_x,
    output logic [rsrd_pkg::FLT_W-1:0]    m_red_a,
    output logic [rsrd_pkg::FLT_W-1:0]    m_green_a,
    output logic [rsrd_pkg::FLT_W-1:0]    m_blue_a,
    output logic [rsrd_pkg::FLT_W-1:0]    m_red_b,
    output logic [rsrd_pkg::FLT_W-1:0]    m_green_b,
    output logic [rsrd_pkg::FLT_W-1:0]    m_blue_b,
    output logic                          m_second_valid,
    output logic                          m_row_end,
    output logic                          m_last_of_item,
    output logic [2:0]                    m_error_code
);
    import rsrd_pkg::*;

    localparam logic [2:0] PH_MAGIC1  = 3'd0;
    localparam logic [2:0] PH_MAGIC2  = 3'd1;
    localparam logic [2:0] PH_WHIGH   = 3'd2;
    localparam logic [2:0] PH_WLOW    = 3'd3;
    localparam logic [2:0] PH_COUNT   = 3'd4;
    localparam logic [2:0] PH_RUNVAL  = 3'd5;
    localparam logic [2:0] PH_LITERAL = 3'd6;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ERR   = 3'd1;
    localparam logic [2:0] ST_STORE = 3'd2;
    localparam logic [2:0] ST_CR    = 3'd3;
    localparam logic [2:0] ST_CG    = 3'd4;
    localparam logic [2:0] ST_CB    = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    logic [2:0]        st_reg;
    logic [2:0]        phase_reg;
    logic [1:0]        plane_reg;
    logic [RW_W-1:0]   pos_reg;
    logic [7:0]        pend_reg;
    logic [7:0]        whigh_reg;
    logic [RW_W-1:0]   row_width_reg;
    logic [7:0]        byte_reg;
    logic [7:0]        rep_reg;
    logic              lit_reg;
    logic              half_reg;
    logic              end_reg;
    logic              xhi_reg;
    logic [ADDR_W-1:0] x_reg;
    logic [2:0]        err_reg;

    logic [ADDR_W-1:0] wk_x;
    logic [FLT_W-1:0]  wk_ra, wk_ga, wk_ba, wk_rb, wk_gb, wk_bb;
    logic              wk_sv, wk_end;

    logic              accept, out_free, out_load;
    logic [RW_W-1:0]   pos_inc;
    logic              plane_end;
    logic [7:0]        rep_dec;
    logic              done_now;
    logic [7:0]        run_n;
    logic [15:0]       hdr_w;
    logic [7:0]        r_q, g_q, b_q;
    logic [7:0]        conv_m;
    logic [FLT_W-1:0]  conv_f;
    logic [ADDR_W-1:0] ram_addr;
    logic              store_cyc;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (st_reg == ST_IDLE);
    assign out_free = !m_valid || m_ready;
    assign out_load = out_free && (st_reg == ST_ERR || st_reg == ST_EMIT);

    assign pos_inc   = pos_reg + 1'b1;
    assign plane_end = (pos_inc >= row_width_reg);
    assign rep_dec   = rep_reg - 1'b1;
    assign done_now  = plane_end || (rep_dec == 8'd0);
    assign run_n     = (s_data_byte > RUN_BASE) ? s_data_byte - RUN_BASE : s_data_byte;
    assign hdr_w     = {whigh_reg, s_data_byte};

    assign store_cyc = (st_reg == ST_STORE);
    assign ram_addr  = store_cyc ? pos_reg[ADDR_W-1:0] : x_reg;

    rsrd_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_WIDTH)) u_red (
        .aclk(aclk), .we(store_cyc && plane_reg == 2'd0 && !pos_reg[ADDR_W]),
        .addr(ram_addr), .wdata(byte_reg), .rdata(r_q));
    rsrd_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_WIDTH)) u_green (
        .aclk(aclk), .we(store_cyc && plane_reg == 2'd1 && !pos_reg[ADDR_W]),
        .addr(ram_addr), .wdata(byte_reg), .rdata(g_q));
    rsrd_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_WIDTH)) u_blue (
        .aclk(aclk), .we(store_cyc && plane_reg == 2'd2 && !pos_reg[ADDR_W]),
        .addr(ram_addr), .wdata(byte_reg), .rdata(b_q));

    // One converter serves all three channels in turn.
    always_comb begin
        case (st_reg)
            ST_CG:   conv_m = g_q;
            ST_CB:   conv_m = b_q;
            default: conv_m = r_q;
        endcase
        if (xhi_reg) conv_m = 8'd0;
        conv_f = rgbe_to_float(conv_m, byte_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            phase_reg     <= PH_MAGIC1;
            plane_reg     <= 2'd0;
            pos_reg       <= '0;
            pend_reg      <= '0;
            whigh_reg     <= '0;
            row_width_reg <= RW_W'(1);
            half_reg      <= 1'b0;
            m_valid       <= 1'b0;
        end else begin
            if (cfg_we) row_width_reg <= cfg_wdata;
            if (out_load) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end

            unique case (st_reg)
                ST_IDLE: begin
                    if (accept) begin
                        byte_reg <= s_data_byte;
                        half_reg <= 1'b0;
                        unique case (phase_reg)
                            PH_MAGIC1, PH_MAGIC2: begin
                                if (s_data_byte == MAGIC_BYTE) begin
                                    phase_reg <= (phase_reg == PH_MAGIC1) ? PH_MAGIC2 : PH_WHIGH;
                                end else begin
                                    err_reg <= ERR_MAGIC;
                                    st_reg  <= ST_ERR;
                                end
                            end
                            PH_WHIGH: begin
                                whigh_reg <= s_data_byte;
                                phase_reg <= PH_WLOW;
                            end
                            PH_WLOW: begin
                                if (hdr_w != {3'b000, row_width_reg} || row_width_reg == '0
                                    || row_width_reg > RW_W'(MAX_WIDTH)) begin
                                    err_reg <= ERR_WIDTH;
                                    st_reg  <= ST_ERR;
                                end else begin
                                    phase_reg <= PH_COUNT;
                                    plane_reg <= 2'd0;
                                    pos_reg   <= '0;
                                    pend_reg  <= '0;
                                end
                            end
                            PH_COUNT: begin
                                if (s_data_byte == 8'd0) begin
                                    err_reg <= ERR_ZERO_RUN;
                                    st_reg  <= ST_ERR;
                                end else if (({1'b0, pos_reg} + {6'b0, run_n})
                                             > {1'b0, row_width_reg}) begin
                                    err_reg <= ERR_OVERRUN;
                                    st_reg  <= ST_ERR;
                                end else begin
                                    pend_reg  <= run_n;
                                    phase_reg <= (s_data_byte > RUN_BASE) ? PH_RUNVAL
                                                                          : PH_LITERAL;
                                end
                            end
                            PH_RUNVAL: begin
                                rep_reg   <= pend_reg;
                                pend_reg  <= '0;
                                phase_reg <= PH_COUNT;
                                lit_reg   <= 1'b0;
                                // A run with nothing pending stores nothing.
                                st_reg    <= (pend_reg == 8'd0) ? ST_IDLE : ST_STORE;
                            end
                            PH_LITERAL: begin
                                if (pend_reg != 8'd0) pend_reg <= pend_reg - 1'b1;
                                rep_reg <= 8'd1;
                                lit_reg <= 1'b1;
                                st_reg  <= ST_STORE;
                            end
                            default: begin
                                err_reg <= ERR_MAGIC;
                                st_reg  <= ST_ERR;
                            end
                        endcase
                    end
                end
                ST_ERR: begin
                    phase_reg <= PH_MAGIC1;
                    plane_reg <= 2'd0;
                    pos_reg   <= '0;
                    pend_reg  <= '0;
                    if (out_free) begin
                        m_pixel_x      <= '0;
                        m_red_a        <= '0;
                        m_green_a      <= '0;
                        m_blue_a       <= '0;
                        m_red_b        <= '0;
                        m_green_b      <= '0;
                        m_blue_b       <= '0;
                        m_second_valid <= 1'b0;
                        m_row_end      <= 1'b0;
                        m_last_of_item <= 1'b1;
                        m_error_code   <= err_reg;
                        st_reg         <= ST_IDLE;
                    end
                end
                ST_STORE: begin
                    rep_reg <= rep_dec;
                    end_reg <= plane_end;
                    x_reg   <= pos_reg[ADDR_W-1:0];
                    xhi_reg <= pos_reg[ADDR_W];
                    if (plane_end) begin
                        pos_reg  <= '0;
                        pend_reg <= '0;
                        if (plane_reg == 2'd3) begin
                            phase_reg <= PH_MAGIC1;
                            plane_reg <= 2'd0;
                        end else begin
                            plane_reg <= plane_reg + 1'b1;
                            phase_reg <= PH_COUNT;
                        end
                    end else begin
                        pos_reg <= pos_inc;
                        if (lit_reg && pend_reg == 8'd0) phase_reg <= PH_COUNT;
                    end
                    if (plane_reg == 2'd3) begin
                        if (!half_reg) begin
                            wk_x   <= pos_reg[ADDR_W-1:0];
                            wk_end <= plane_end;
                            wk_sv  <= 1'b0;
                            wk_rb  <= '0;
                            wk_gb  <= '0;
                            wk_bb  <= '0;
                        end else begin
                            wk_end <= wk_end | plane_end;
                            wk_sv  <= 1'b1;
                        end
                        st_reg <= ST_CR;
                    end else if (done_now) begin
                        st_reg <= ST_IDLE;
                    end
                end
                ST_CR: begin
                    if (half_reg) wk_rb <= conv_f; else wk_ra <= conv_f;
                    st_reg <= ST_CG;
                end
                ST_CG: begin
                    if (half_reg) wk_gb <= conv_f; else wk_ga <= conv_f;
                    st_reg <= ST_CB;
                end
                ST_CB: begin
                    if (half_reg) wk_bb <= conv_f; else wk_ba <= conv_f;
                    if (half_reg || end_reg || rep_reg == 8'd0) begin
                        half_reg <= 1'b0;
                        st_reg   <= ST_EMIT;
                    end else begin
                        half_reg <= 1'b1;
                        st_reg   <= ST_STORE;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_pixel_x      <= wk_x;
                        m_red_a        <= wk_ra;
                        m_green_a      <= wk_ga;
                        m_blue_a       <= wk_ba;
                        m_red_b        <= wk_rb;
                        m_green_b      <= wk_gb;
                        m_blue_b       <= wk_bb;
                        m_second_valid <= wk_sv;
                        m_row_end      <= wk_end;
                        m_last_of_item <= end_reg || rep_reg == 8'd0;
                        m_error_code   <= ERR_NONE;
                        st_reg <= (end_reg || rep_reg == 8'd0) ? ST_IDLE : ST_STORE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
